FILE: rtl/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// shared types and codes of the five-stage pipeline block
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam int INSTR_WIDTH = 16;
    localparam int PC_WIDTH    = 9;
    localparam int REG_COUNT   = 8;

    typedef enum logic [1:0] {
        CMD_LOAD_INSTR = 2'd0,
        CMD_LOAD_DATA  = 2'd1,
        CMD_STEP       = 2'd2,
        CMD_RESTART    = 2'd3
    } cmd_t;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_EXEC = 1'b1
    } phase_t;

    // opcodes
    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    // r-type function codes
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd2;
    localparam logic [2:0] FN_AND = 3'd4;
    localparam logic [2:0] FN_OR  = 3'd5;

endpackage

FILE: rtl/mrp_if.sv
// ----------------------------------------------------------------------------
// mrp channel interfaces
// command, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface mrp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] address;
    logic [15:0] word;
    modport source (output valid, command, address, word, input ready);
    modport sink   (input valid, command, address, word, output ready);
endinterface

interface mrp_rsp_if #(parameter int DW = 16);
    logic          valid;
    logic          ready;
    logic [8:0]    program_counter;
    logic          halted;
    logic          reg_written;
    logic [2:0]    reg_index;
    logic [DW-1:0] reg_value;
    logic          mem_written;
    logic [7:0]    mem_address;
    logic [DW-1:0] mem_value;
    logic          redirect_taken;
    modport source (output valid, program_counter, halted, reg_written, reg_index, reg_value,
                    mem_written, mem_address, mem_value, redirect_taken, input ready);
    modport sink   (input valid, program_counter, halted, reg_written, reg_index, reg_value,
                    mem_written, mem_address, mem_value, redirect_taken, output ready);
endinterface

interface mrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/mrp_ram.sv
// ----------------------------------------------------------------------------
// mrp_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module mrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/five_stage_mini_risc_pipeline.sv
// ----------------------------------------------------------------------------
// five_stage_mini_risc_pipeline
// 16-bit five-stage pipeline advanced by one step per step command
// ----------------------------------------------------------------------------
//  channel | dir | transfer when       | payload
//  req     | in  | req.valid&req.ready | command, address, word
//  rsp     | out | rsp.valid&rsp.ready | pc, halt, writeback, store, redirect
//  cfg     | in  | cfg.valid&cfg.ready | program_length (always ready)
//
//  each command has two phases: the accept cycle issues the memory and
//  register file reads, the evaluation cycle evaluates all stages and writes
//  back; the result is valid the cycle after evaluation; no new command is
//  taken during evaluation, and a result not yet taken holds off the next one
//  after reset a clearing pass writes zeros to all MEMORY_DEPTH entries (256 by
//  default) of both memories, with req.ready low
//  restart clears pipeline and register valid bits
module five_stage_mini_risc_pipeline
    import mrp_pkg::*;
#(
    parameter int MEMORY_DEPTH = 256,
    parameter int DATA_WIDTH   = 16
) (
    input  logic clk,
    input  logic rst_n,
    mrp_req_if.sink   req,
    mrp_rsp_if.source rsp,
    mrp_cfg_if.sink   cfg
);

    localparam int AW    = $clog2(MEMORY_DEPTH);
    localparam int DW    = DATA_WIDTH;
    localparam int SH    = 24;
    localparam int RECIP = (1 << SH) / MEMORY_DEPTH;

    // modulo by the memory depth: reciprocal estimate plus one correction
    function automatic logic [AW-1:0] mod_depth(input logic [15:0] x);
        logic [40:0] prod;
        logic [15:0] q;
        logic [31:0] r;
        prod = 41'(x) * 41'(RECIP);
        q    = prod[SH+15:SH];
        r    = 32'(x) - 32'(q) * 32'(MEMORY_DEPTH);
        if (r >= 32'(MEMORY_DEPTH))
        begin
            r = r - 32'(MEMORY_DEPTH);
        end
        return r[AW-1:0];
    endfunction

    // control and architectural state
    phase_t phase_reg, phase_next;
    cmd_t   cmd_reg;
    logic                halt_reg, halt_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic [PC_WIDTH-1:0] plen_reg;
    logic                redir_v_reg, redir_v_next;
    logic [AW-1:0]       redir_tgt_reg, redir_tgt_next;
    logic [REG_COUNT-1:0]    rf_v_reg, rf_v_next;

    // memory clearing pass after reset
    logic                clr_busy_reg;
    logic [AW-1:0]       clr_addr_reg;

    // pipeline latches
    logic [INSTR_WIDTH-1:0] f_word_reg, f_word_next, d_word_reg, d_word_next;
    logic [PC_WIDTH-1:0]    f_seq_reg, f_seq_next, d_seq_reg, d_seq_next;
    logic [DW-1:0]          d_va_reg, d_va_next, d_vb_reg, d_vb_next;
    logic [3:0]             e_op_reg, e_op_next, m_op_reg, m_op_next;
    logic [DW-1:0]          e_res_reg, e_res_next, e_sv_reg, e_sv_next;
    logic [2:0]             e_dest_reg, e_dest_next, m_dest_reg, m_dest_next;
    logic [DW-1:0]          m_ld_reg, m_ld_next, m_res_reg, m_res_next;

    // output register
    logic                out_v_reg, out_v_next;
    logic [PC_WIDTH-1:0] o_pc_reg;
    logic                o_halt_reg, o_rw_reg, o_mw_reg, o_tk_reg;
    logic [2:0]          o_ridx_reg;
    logic [DW-1:0]       o_rval_reg, o_mval_reg;
    logic [7:0]          o_maddr_reg;

    logic accept, step_go, restart_go;
    logic [AW-1:0] load_addr;

    // memory ports
    logic                   imem_we, imem_wr_en;
    logic [AW-1:0]          imem_waddr;
    logic [INSTR_WIDTH-1:0] imem_wdata;
    logic [INSTR_WIDTH-1:0] imem_q, fetch_word;
    logic                   dmem_we;
    logic [AW-1:0]          dmem_waddr, dmem_raddr;
    logic [DW-1:0]          dmem_wdata, dmem_q;
    logic [AW-1:0]          imem_raddr;
    logic [DW-1:0]          rfa_q, rfb_q;

    // stage combinational values
    logic          wb_we;
    logic [DW-1:0] wb_val;
    logic          st_we;
    logic [DW-1:0] ra_val, rb_val;
    logic          taken;

    assign accept     = req.valid && req.ready;
    assign req.ready  = !clr_busy_reg && (phase_reg == PH_IDLE) && (!out_v_reg || rsp.ready);
    assign cfg.ready  = 1'b1;
    assign step_go    = (phase_reg == PH_EXEC) && (cmd_reg == CMD_STEP) && !halt_reg;
    assign restart_go = (phase_reg == PH_EXEC) && (cmd_reg == CMD_RESTART);
    assign load_addr  = mod_depth(16'(req.address));

    // instruction memory: loads write on accept, fetch reads at the pc
    assign imem_we    = accept && (cmd_t'(req.command) == CMD_LOAD_INSTR);
    assign imem_wr_en = clr_busy_reg || imem_we;
    assign imem_waddr = clr_busy_reg ? clr_addr_reg : load_addr;
    assign imem_wdata = clr_busy_reg ? '0 : req.word;
    assign imem_raddr = mod_depth(16'(pc_reg));

    mrp_ram #(.WIDTH(INSTR_WIDTH), .DEPTH(MEMORY_DEPTH)) u_imem (
        .clk   (clk),
        .we    (imem_wr_en),
        .waddr (imem_waddr),
        .wdata (imem_wdata),
        .raddr (imem_raddr),
        .rdata (imem_q)
    );

    // data memory: loads on accept, stores from the memory stage
    assign dmem_raddr = mod_depth(16'(e_res_reg));
    assign st_we      = step_go && (e_op_reg == OP_SW);
    assign dmem_we    = clr_busy_reg || st_we
                        || (accept && (cmd_t'(req.command) == CMD_LOAD_DATA));
    assign dmem_waddr = clr_busy_reg ? clr_addr_reg : (st_we ? dmem_raddr : load_addr);
    assign dmem_wdata = clr_busy_reg ? '0 : (st_we ? e_sv_reg : DW'(req.word));

    mrp_ram #(.WIDTH(DW), .DEPTH(MEMORY_DEPTH)) u_dmem (
        .clk   (clk),
        .we    (dmem_we),
        .waddr (dmem_waddr),
        .wdata (dmem_wdata),
        .raddr (dmem_raddr),
        .rdata (dmem_q)
    );

    // register file: two copies give the two decode read ports
    mrp_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (wb_we),
        .waddr (m_dest_reg),
        .wdata (wb_val),
        .raddr (f_word_reg[11:9]),
        .rdata (rfa_q)
    );

    mrp_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (wb_we),
        .waddr (m_dest_reg),
        .wdata (wb_val),
        .raddr (f_word_reg[8:6]),
        .rdata (rfb_q)
    );

    // write-back stage
    assign wb_we  = step_go && ((m_op_reg == OP_RTYPE) || (m_op_reg == OP_ADDI)
                                || (m_op_reg == OP_LW));
    assign wb_val = (m_op_reg == OP_LW) ? m_ld_reg : m_res_reg;

    // decode reads see this cycle's write-back; registers cleared by restart read zero
    always_comb
    begin
        if (wb_we && (m_dest_reg == f_word_reg[11:9]))
            ra_val = wb_val;
        else
            ra_val = rf_v_reg[f_word_reg[11:9]] ? rfa_q : '0;
        if (wb_we && (m_dest_reg == f_word_reg[8:6]))
            rb_val = wb_val;
        else
            rb_val = rf_v_reg[f_word_reg[8:6]] ? rfb_q : '0;
    end

    assign fetch_word = imem_q;

    // phase sequencing
    always_comb
    begin
        unique case (phase_reg)
            PH_IDLE: phase_next = accept ? PH_EXEC : PH_IDLE;
            PH_EXEC: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // stage evaluation
    always_comb
    begin
        logic [3:0]          d_op;
        logic [5:0]          imm6;
        logic [DW-1:0]       alu;
        logic [15:0]         btgt;
        d_op = d_word_reg[15:12];
        imm6 = d_word_reg[5:0];
        alu  = '0;
        // branch target wraps at 16 bits before the memory modulo
        btgt = 16'(d_seq_reg) + {{10{imm6[5]}}, imm6};

        halt_next      = halt_reg;
        pc_next        = pc_reg;
        redir_v_next   = redir_v_reg;
        redir_tgt_next = redir_tgt_reg;
        rf_v_next      = rf_v_reg;
        f_word_next    = f_word_reg;
        f_seq_next     = f_seq_reg;
        d_word_next    = d_word_reg;
        d_seq_next     = d_seq_reg;
        d_va_next      = d_va_reg;
        d_vb_next      = d_vb_reg;
        e_op_next      = e_op_reg;
        e_res_next     = e_res_reg;
        e_sv_next      = e_sv_reg;
        e_dest_next    = e_dest_reg;
        m_op_next      = m_op_reg;
        m_ld_next      = m_ld_reg;
        m_res_next     = m_res_reg;
        m_dest_next    = m_dest_reg;
        taken          = 1'b0;

        if (restart_go)
        begin
            halt_next    = 1'b0;
            pc_next      = '0;
            redir_v_next = 1'b0;
            redir_tgt_next = '0;
            rf_v_next    = '0;
            f_word_next  = '0;
            f_seq_next   = '0;
            d_word_next  = '0;
            d_seq_next   = '0;
            d_va_next    = '0;
            d_vb_next    = '0;
            e_op_next    = '0;
            e_res_next   = '0;
            e_sv_next    = '0;
            e_dest_next  = '0;
            m_op_next    = '0;
            m_ld_next    = '0;
            m_res_next   = '0;
            m_dest_next  = '0;
        end
        else if (step_go)
        begin
            if (wb_we)
            begin
                rf_v_next[m_dest_reg] = 1'b1;
            end

            // memory
            if (e_op_reg == OP_LW)
            begin
                m_ld_next = dmem_q;
            end
            m_res_next  = e_res_reg;
            m_dest_next = e_dest_reg;
            m_op_next   = e_op_reg;

            // execute
            if (d_op == OP_RTYPE)
            begin
                unique case (d_word_reg[2:0])
                    FN_ADD:  alu = d_va_reg + d_vb_reg;
                    FN_SUB:  alu = d_va_reg - d_vb_reg;
                    FN_AND:  alu = d_va_reg & d_vb_reg;
                    FN_OR:   alu = d_va_reg | d_vb_reg;
                    default: alu = '0;
                endcase
                e_res_next  = alu;
                e_dest_next = d_word_reg[5:3];
            end
            else if (d_op == OP_ADDI)
            begin
                e_res_next  = d_va_reg + DW'(imm6);
                e_dest_next = d_word_reg[8:6];
            end
            else if ((d_op == OP_LW) || (d_op == OP_SW))
            begin
                e_res_next  = d_va_reg + DW'(imm6);
                e_sv_next   = d_vb_reg;
                e_dest_next = d_word_reg[8:6];
            end
            else if (d_op == OP_BEQ)
            begin
                if (d_va_reg == d_vb_reg)
                begin
                    redir_tgt_next = mod_depth(btgt);
                    redir_v_next   = 1'b1;
                    taken          = 1'b1;
                end
            end
            else if (d_op == OP_JUMP)
            begin
                redir_tgt_next = mod_depth(16'(d_word_reg[11:0]));
                redir_v_next   = 1'b1;
                taken          = 1'b1;
            end
            e_op_next = d_op;

            // decode
            d_word_next = f_word_reg;
            d_seq_next  = f_seq_reg;
            d_va_next   = ra_val;
            d_vb_next   = rb_val;

            // fetch; a taken redirect injects a zero word
            if (redir_v_next)
            begin
                pc_next      = PC_WIDTH'(redir_tgt_next);
                redir_v_next = 1'b0;
                f_word_next  = '0;
                f_seq_next   = '0;
            end
            else
            begin
                f_word_next = fetch_word;
                f_seq_next  = pc_reg + PC_WIDTH'(1);
                pc_next     = pc_reg + PC_WIDTH'(1);
            end

            if (pc_next >= plen_reg)
            begin
                halt_next = 1'b1;
            end
        end
    end

    assign out_v_next = (phase_reg == PH_EXEC) || (out_v_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= CMD_LOAD_INSTR;
            halt_reg      <= 1'b0;
            pc_reg        <= '0;
            plen_reg      <= '0;
            redir_v_reg   <= 1'b0;
            redir_tgt_reg <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            rf_v_reg      <= '0;
            f_word_reg    <= '0;
            f_seq_reg     <= '0;
            d_word_reg    <= '0;
            d_seq_reg     <= '0;
            d_va_reg      <= '0;
            d_vb_reg      <= '0;
            e_op_reg      <= '0;
            e_res_reg     <= '0;
            e_sv_reg      <= '0;
            e_dest_reg    <= '0;
            m_op_reg      <= '0;
            m_ld_reg      <= '0;
            m_res_reg     <= '0;
            m_dest_reg    <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            halt_reg      <= halt_next;
            pc_reg        <= pc_next;
            redir_v_reg   <= redir_v_next;
            redir_tgt_reg <= redir_tgt_next;
            rf_v_reg      <= rf_v_next;
            f_word_reg    <= f_word_next;
            f_seq_reg     <= f_seq_next;
            d_word_reg    <= d_word_next;
            d_seq_reg     <= d_seq_next;
            d_va_reg      <= d_va_next;
            d_vb_reg      <= d_vb_next;
            e_op_reg      <= e_op_next;
            e_res_reg     <= e_res_next;
            e_sv_reg      <= e_sv_next;
            e_dest_reg    <= e_dest_next;
            m_op_reg      <= m_op_next;
            m_ld_reg      <= m_ld_next;
            m_res_reg     <= m_res_next;
            m_dest_reg    <= m_dest_next;
            out_v_reg     <= out_v_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MEMORY_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                cmd_reg <= cmd_t'(req.command);
            end
            if (cfg.valid)
            begin
                plen_reg <= cfg.data;
            end
        end
    end

    // result register, loaded in the evaluation cycle
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_EXEC)
        begin
            o_pc_reg    <= pc_next;
            o_halt_reg  <= halt_next;
            o_rw_reg    <= wb_we;
            o_ridx_reg  <= wb_we ? m_dest_reg : 3'd0;
            o_rval_reg  <= wb_we ? wb_val : '0;
            o_mw_reg    <= st_we;
            o_maddr_reg <= st_we ? 8'(dmem_raddr) : 8'd0;
            o_mval_reg  <= st_we ? e_sv_reg : '0;
            o_tk_reg    <= taken;
        end
    end

    assign rsp.valid           = out_v_reg;
    assign rsp.program_counter = o_pc_reg;
    assign rsp.halted          = o_halt_reg;
    assign rsp.reg_written     = o_rw_reg;
    assign rsp.reg_index       = o_ridx_reg;
    assign rsp.reg_value       = o_rval_reg;
    assign rsp.mem_written     = o_mw_reg;
    assign rsp.mem_address     = o_maddr_reg;
    assign rsp.mem_value       = o_mval_reg;
    assign rsp.redirect_taken  = o_tk_reg;

endmodule

FILE: rtl/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_port_checks
// port-level checks on the command and result channels of the pipeline block
// ----------------------------------------------------------------------------
module mrp_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        reg_written,
    input logic [2:0]  reg_index,
    input logic        mem_written,
    input logic [7:0]  mem_address,
    input logic        halted,
    input logic        redirect_taken
);

    // a held result stays
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // idle writeback index reads zero
    a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !reg_written |-> reg_index == 3'd0)
        else $error("writeback index set without write");

    // idle store address reads zero
    a_st_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !mem_written |-> mem_address == 8'd0)
        else $error("store address set without store");

    // a command taken gives a result once the evaluation phase has loaded the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> ##1 rsp_valid)
        else $error("result missing after command");

    // a held result keeps its status fields
    a_status_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({halted, redirect_taken}))
        else $error("status changed while stalled");

endmodule

bind five_stage_mini_risc_pipeline mrp_port_checks u_mrp_port_checks (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .reg_written    (rsp.reg_written),
    .reg_index      (rsp.reg_index),
    .mem_written    (rsp.mem_written),
    .mem_address    (rsp.mem_address),
    .halted         (rsp.halted),
    .redirect_taken (rsp.redirect_taken)
);

FILE: tb/mrp_tb_if.sv
// ----------------------------------------------------------------------------
// testbench channel note
// the channel interfaces of the block are reused as they are; this file only
// holds the instruction-word encoders used by the stimulus
// ----------------------------------------------------------------------------
package mrp_tb_pkg;
    import mrp_pkg::*;

    function automatic logic [15:0] enc_r(logic [2:0] rs, logic [2:0] rt, logic [2:0] rd,
                                          logic [2:0] fn);
        return {OP_RTYPE, rs, rt, rd, fn};
    endfunction

    function automatic logic [15:0] enc_i(logic [3:0] op, logic [2:0] rs, logic [2:0] rt,
                                          logic [5:0] imm);
        return {op, rs, rt, imm};
    endfunction

endpackage

FILE: tb/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_checker
// watches the command, result and configuration channels, predicts each result of
// the pipeline and compares it field by field
// ----------------------------------------------------------------------------
module mrp_checker
    import mrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mrp_req_if req,
    mrp_rsp_if rsp,
    mrp_cfg_if cfg,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [8:0]  program_counter;
        logic        halted;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [7:0]  mem_address;
        logic [15:0] mem_value;
        logic        redirect_taken;
    } cpu_out_t;

    cpu_out_t    result_q[$];
    logic [15:0] imem[256];
    logic [15:0] dmem[256];
    logic [15:0] regs[8];
    logic [8:0]  pc;
    logic        halt;
    logic [8:0]  prog_len;
    logic        redir_v;
    logic [7:0]  redir_t;
    logic [15:0] f_word;
    logic [8:0]  f_seq;
    logic [3:0]  d_op;
    logic [2:0]  d_ra, d_rb, d_rw, d_fn;
    logic [5:0]  d_imm;
    logic [11:0] d_jt;
    logic [8:0]  d_seq;
    logic [15:0] d_va, d_vb;
    logic [3:0]  e_op;
    logic [15:0] e_res, e_sv;
    logic [2:0]  e_dst;
    logic [3:0]  m_op;
    logic [15:0] m_ld, m_res;
    logic [2:0]  m_dst;

    function automatic void clear_core();
        foreach (regs[i]) regs[i] = '0;
        pc = '0; halt = 0; redir_v = 0; redir_t = '0;
        f_word = '0; f_seq = '0;
        d_op = '0; d_ra = '0; d_rb = '0; d_rw = '0; d_fn = '0; d_imm = '0; d_jt = '0;
        d_seq = '0; d_va = '0; d_vb = '0;
        e_op = '0; e_res = '0; e_sv = '0; e_dst = '0;
        m_op = '0; m_ld = '0; m_res = '0; m_dst = '0;
    endfunction

    function automatic cpu_out_t run_command(cmd_t c, logic [7:0] a, logic [15:0] w);
        cpu_out_t    o;
        logic [15:0] r, off;
        o = '0;
        case (c)
            CMD_LOAD_INSTR: imem[a] = w;
            CMD_LOAD_DATA:  dmem[a] = w;
            CMD_RESTART:    clear_core();
            default:
                if (!halt)
                begin
                    // writeback
                    if (m_op == OP_RTYPE || m_op == OP_ADDI || m_op == OP_LW)
                    begin
                        o.reg_written = 1;
                        o.reg_index = m_dst;
                        o.reg_value = (m_op == OP_LW) ? m_ld : m_res;
                        regs[m_dst] = o.reg_value;
                    end
                    // memory
                    if (e_op == OP_LW)
                        m_ld = dmem[e_res[7:0]];
                    else if (e_op == OP_SW)
                    begin
                        dmem[e_res[7:0]] = e_sv;
                        o.mem_written = 1;
                        o.mem_address = e_res[7:0];
                        o.mem_value = e_sv;
                    end
                    m_res = e_res; m_dst = e_dst; m_op = e_op;
                    // execute
                    case (d_op)
                        OP_RTYPE:
                        begin
                            case (d_fn)
                                FN_ADD:  r = d_va + d_vb;
                                FN_SUB:  r = d_va - d_vb;
                                FN_AND:  r = d_va & d_vb;
                                FN_OR:   r = d_va | d_vb;
                                default: r = '0;
                            endcase
                            e_res = r; e_dst = d_rw;
                        end
                        OP_ADDI:
                        begin
                            e_res = d_va + d_imm; e_dst = d_rb;
                        end
                        OP_LW, OP_SW:
                        begin
                            e_res = d_va + d_imm; e_sv = d_vb; e_dst = d_rb;
                        end
                        OP_BEQ:
                            if (d_va == d_vb)
                            begin
                                off = {{10{d_imm[5]}}, d_imm};
                                r = 16'(d_seq) + off;
                                redir_t = r[7:0]; redir_v = 1; o.redirect_taken = 1;
                            end
                        OP_JUMP:
                        begin
                            redir_t = d_jt[7:0]; redir_v = 1; o.redirect_taken = 1;
                        end
                        default: ;
                    endcase
                    e_op = d_op;
                    // decode
                    d_op = f_word[15:12]; d_ra = f_word[11:9]; d_rb = f_word[8:6];
                    d_rw = f_word[5:3]; d_fn = f_word[2:0]; d_imm = f_word[5:0];
                    d_jt = f_word[11:0]; d_seq = f_seq;
                    d_va = regs[d_ra]; d_vb = regs[d_rb];
                    // fetch
                    if (redir_v)
                    begin
                        pc = {1'b0, redir_t}; redir_v = 0; f_word = '0; f_seq = '0;
                    end
                    else
                    begin
                        f_word = imem[pc[7:0]]; f_seq = pc + 9'd1; pc = f_seq;
                    end
                    if (pc >= prog_len)
                        halt = 1;
                end
        endcase
        o.program_counter = pc;
        o.halted = halt;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cpu_out_t got, want;
        if (!rst_n)
        begin
            foreach (imem[i]) imem[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            prog_len = '0;
            clear_core();
            result_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                prog_len = cfg.data;
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.program_counter, rsp.halted, rsp.reg_written, rsp.reg_index,
                        rsp.reg_value, rsp.mem_written, rsp.mem_address, rsp.mem_value,
                        rsp.redirect_taken};
                if (result_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.program_counter !== want.program_counter)
                        begin $error("program_counter exp %0d got %0d", want.program_counter,
                                     got.program_counter); errors++; end
                    if (got.halted !== want.halted)
                        begin $error("halted exp %0d got %0d", want.halted, got.halted);
                              errors++; end
                    if (got.reg_written !== want.reg_written)
                        begin $error("reg_written exp %0d got %0d", want.reg_written,
                                     got.reg_written); errors++; end
                    if (got.reg_index !== want.reg_index)
                        begin $error("reg_index exp %0d got %0d", want.reg_index,
                                     got.reg_index); errors++; end
                    if (got.reg_value !== want.reg_value)
                        begin $error("reg_value exp %h got %h", want.reg_value,
                                     got.reg_value); errors++; end
                    if (got.mem_written !== want.mem_written)
                        begin $error("mem_written exp %0d got %0d", want.mem_written,
                                     got.mem_written); errors++; end
                    if (got.mem_address !== want.mem_address)
                        begin $error("mem_address exp %0d got %0d", want.mem_address,
                                     got.mem_address); errors++; end
                    if (got.mem_value !== want.mem_value)
                        begin $error("mem_value exp %h got %h", want.mem_value,
                                     got.mem_value); errors++; end
                    if (got.redirect_taken !== want.redirect_taken)
                        begin $error("redirect_taken exp %0d got %0d", want.redirect_taken,
                                     got.redirect_taken); errors++; end
                end
            end
            // prediction after the compare so a same-edge result never meets its own item
            if (req.valid && req.ready)
                result_q.push_back(run_command(cmd_t'(req.command), req.address, req.word));
            pending = result_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the five-stage pipeline: loads small programs,
// steps them with bursty commands and a stalling result sink
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mrp_pkg::*;
    import mrp_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   sent = 0;
    logic long_hold = 0;

    mrp_req_if req();
    mrp_rsp_if #(.DW(16)) rsp();
    mrp_cfg_if cfg();

    five_stage_mini_risc_pipeline uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));
    mrp_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
                     .errors(errors), .pending(pending));

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        req.valid = 0; req.command = CMD_STEP; req.address = '0; req.word = '0;
        cfg.valid = 0; cfg.data = '0;
        rsp.ready = 0;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result sink: own stall pattern, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (long_hold)
            rsp.ready <= 0;
        else
            rsp.ready <= (cycles % 16 < 11) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end

    // one command transfer; bursts of random length with random gaps
    int burst_left = 0;
    task automatic send(cmd_t c, logic [7:0] a, logic [15:0] w);
        if (burst_left == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req.valid <= 1; req.command <= c; req.address <= a; req.word <= w;
        do @(posedge clk); while (!req.ready);
        sent++;
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic set_length(logic [8:0] len);
        drain();
        cfg.valid <= 1; cfg.data <= len;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
    endtask

    task automatic steps(int n);
        repeat (n) send(CMD_STEP, 8'($urandom), 16'($urandom));
    endtask

    // mostly valid instructions with few source registers, so results repeat
    function automatic logic [15:0] rand_instr();
        logic [2:0] rs, rt, rd;
        rs = $urandom_range(0, 3); rt = $urandom_range(0, 3); rd = $urandom_range(0, 7);
        case ($urandom_range(0, 11))
            0, 1, 2: return enc_r(rs, rt, rd, 3'($urandom_range(0, 7)));
            3, 4:    return enc_i(OP_ADDI, rs, rd, 6'($urandom));
            5:       return enc_i(OP_LW, rs, rd, 6'($urandom));
            6:       return enc_i(OP_SW, rs, rt, 6'($urandom));
            7:       return enc_i(OP_BEQ, rs, rt, 6'($urandom));
            8:       return {OP_JUMP, 12'($urandom_range(0, 40))};
            9:       return {OP_JUMP, 12'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero program length: the first step halts, further steps do nothing
        steps(3);
        set_length(9'd256);
        // directed program: every op, wrap, sub, unknown funct, unknown opcode
        send(CMD_LOAD_DATA, 8'd255, 16'hFFFF);
        send(CMD_LOAD_DATA, 8'd0, 16'h8000);
        send(CMD_LOAD_INSTR, 8'd0, enc_i(OP_ADDI, 3'd0, 3'd1, 6'h3F));
        send(CMD_LOAD_INSTR, 8'd1, enc_i(OP_LW, 3'd0, 3'd2, 6'h3F));
        send(CMD_LOAD_INSTR, 8'd2, enc_i(OP_LW, 3'd7, 3'd3, 6'h00));
        send(CMD_LOAD_INSTR, 8'd4, enc_r(3'd1, 3'd1, 3'd4, FN_SUB));
        send(CMD_LOAD_INSTR, 8'd5, enc_r(3'd2, 3'd1, 3'd5, FN_ADD));
        send(CMD_LOAD_INSTR, 8'd6, enc_r(3'd2, 3'd3, 3'd6, FN_AND));
        send(CMD_LOAD_INSTR, 8'd7, enc_r(3'd2, 3'd3, 3'd7, FN_OR));
        send(CMD_LOAD_INSTR, 8'd8, enc_r(3'd2, 3'd3, 3'd7, 3'd7));
        send(CMD_LOAD_INSTR, 8'd9, enc_i(OP_SW, 3'd1, 3'd2, 6'h3F));
        send(CMD_LOAD_INSTR, 8'd10, 16'h7ABC);
        send(CMD_LOAD_INSTR, 8'd11, enc_i(OP_BEQ, 3'd0, 3'd0, 6'h3E));
        send(CMD_LOAD_INSTR, 8'd12, {OP_JUMP, 12'hFFF});
        send(CMD_LOAD_INSTR, 8'd255, {OP_JUMP, 12'h000});
        steps(20);
        send(CMD_RESTART, 8'd0, 16'd0);
        steps(4);

        // pressure: hold the sink while commands keep being offered
        long_hold <= 1;
        fork
            begin
                repeat (60) @(posedge clk);
                long_hold <= 0;
            end
            steps(12);
        join

        // random phases over several program lengths, extremes included
        while (sent < 750)
        begin
            case ($urandom_range(0, 4))
                0:       len = 256;
                1:       len = 0;
                2:       len = 1;
                default: len = $urandom_range(4, 40);
            endcase
            set_length(9'(len));
            for (int i = 0; i < 40; i++)
                if ($urandom_range(0, 3) == 0)
                    send(CMD_LOAD_DATA, 8'($urandom), 16'($urandom));
                else
                    send(CMD_LOAD_INSTR, 8'($urandom_range(0, 40)), rand_instr());
            send(CMD_RESTART, 8'($urandom), 16'($urandom));
            for (int i = 0; i < 50; i++)
                case ($urandom_range(0, 19))
                    0:       send(CMD_RESTART, 8'($urandom), 16'($urandom));
                    1:       send(CMD_LOAD_DATA, 8'($urandom), 16'($urandom));
                    2:       send(CMD_LOAD_INSTR, 8'($urandom), 16'($urandom));
                    default: send(CMD_STEP, 8'($urandom), 16'($urandom));
                endcase
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
